### hw/rtl/aah_pkg.sv
// Shared types and constants for the ADC averaging block with hysteresis.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package aah_pkg;

    localparam int CH_W         = 3;   // channel tag width
    localparam int SMP_W        = 10;  // converter sample width
    localparam int SUM_W        = 15;  // burst accumulator width
    localparam int CNT_W        = 5;   // burst sample counter width
    localparam int AVG_W        = 10;  // average / held value width
    localparam int LVL_W        = 8;   // reported level width

    localparam int CHANNELS_DEF = 7;
    localparam int SPR_DEF      = 20;

    // Divide by samples-per-reading as multiply by ceil(2^DIV_SHIFT / n).
    // Exact for any 15-bit sum and any n up to 32.
    localparam int DIV_SHIFT    = 20;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;

    localparam logic [AVG_W-1:0] WINDOW_RESET = AVG_W'(1);

    // Finished burst handed from the accumulator to the filter side
    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [SUM_W-1:0] sum;
    } t_burst;

endpackage

### hw/rtl/aah_front.sv
// Front end: accepts sample requests and keeps per-channel burst sums and counts.
// Pushes a finished burst into the queue. Depends on aah_pkg.
`timescale 1ns / 1ps

module aah_front import aah_pkg::*; #(
    parameter int CHANNELS            = CHANNELS_DEF,
    parameter int SAMPLES_PER_READING = SPR_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [SMP_W-1:0] i_sample,
    output logic             o_push,
    output t_burst           o_entry,
    input  logic             i_full
);

    localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [SUM_W-1:0] r_sum [CHANNELS];
    logic [CNT_W-1:0] r_cnt [CHANNELS];

    logic             w_accept;
    logic             w_in_range;
    logic [CH_IW-1:0] w_idx;
    logic [SUM_W-1:0] w_sum_new;
    logic [CNT_W:0]   w_cnt_new;
    logic             w_done;

    assign w_accept   = i_valid && !i_full;
    assign w_in_range = (CH_W+2)'(i_channel) < (CH_W+2)'(CHANNELS);
    assign w_idx      = CH_IW'(i_channel);
    assign w_sum_new  = r_sum[w_idx] + SUM_W'(i_sample);   // wraps at 15 bits
    assign w_cnt_new  = {1'b0, r_cnt[w_idx]} + (CNT_W+1)'(1);
    assign w_done     = w_cnt_new >= (CNT_W+1)'(SAMPLES_PER_READING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_sum[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else if (w_accept && w_in_range) begin
            if (w_done) begin
                r_sum[w_idx] <= '0;
                r_cnt[w_idx] <= '0;
            end else begin
                r_sum[w_idx] <= w_sum_new;
                r_cnt[w_idx] <= w_cnt_new[CNT_W-1:0];
            end
        end
    end

    assign o_stall     = i_full;
    assign o_push      = w_accept && w_in_range && w_done;
    assign o_entry.ch  = i_channel;
    assign o_entry.sum = w_sum_new;

endmodule

### hw/rtl/aah_fifo.sv
// Short queue of finished bursts between the accumulator and the filter side.
// Depends on aah_pkg.
`timescale 1ns / 1ps

module aah_fifo import aah_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_burst i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_burst o_entry,
    output logic   o_empty
);

    t_burst            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/aah_back.sv
// Back end: divides a burst sum by the reading length, applies the hysteresis
// window against the held value and registers the level. Depends on aah_pkg.
`timescale 1ns / 1ps

module aah_back import aah_pkg::*; #(
    parameter int CHANNELS            = CHANNELS_DEF,
    parameter int SAMPLES_PER_READING = SPR_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    output logic             o_pop,
    input  t_burst           i_entry,
    input  logic             i_cfg_wr_en,
    input  logic [AVG_W-1:0] i_cfg_wr_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CH_W-1:0]  o_out_channel,
    output logic [LVL_W-1:0] o_level
);

    localparam int CH_IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAGIC   = ((1 << DIV_SHIFT) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
    localparam int MAGIC_W = DIV_SHIFT + 1;
    localparam int PROD_W  = SUM_W + MAGIC_W;

    logic [AVG_W-1:0]  r_window;
    logic [AVG_W-1:0]  r_held [CHANNELS];

    logic              r_m_valid;
    logic [CH_W-1:0]   r_m_ch;
    logic [PROD_W-1:0] r_m_prod;

    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_ch;
    logic [LVL_W-1:0]  r_out_level;

    logic              w_out_adv;
    logic              w_m_load;
    logic [CH_IW-1:0]  w_m_idx;
    logic [AVG_W-1:0]  w_avg;
    logic [AVG_W-1:0]  w_held_cur;
    logic [AVG_W-1:0]  w_diff;
    logic              w_update;
    logic [AVG_W-1:0]  w_held_new;

    assign w_out_adv = !r_out_valid || !i_stall;
    assign w_m_load  = !r_m_valid || w_out_adv;
    assign o_pop     = !i_empty && w_m_load;

    // Reciprocal multiply; the quotient sits above DIV_SHIFT
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_ch   <= i_entry.ch;
            r_m_prod <= PROD_W'(i_entry.sum) * PROD_W'(MAGIC);
        end
    end

    assign w_m_idx    = CH_IW'(r_m_ch);
    assign w_avg      = r_m_prod[DIV_SHIFT +: AVG_W];
    assign w_held_cur = r_held[w_m_idx];
    assign w_diff     = (w_avg > w_held_cur) ? (w_avg - w_held_cur) : (w_held_cur - w_avg);
    assign w_update   = w_diff > r_window;
    assign w_held_new = w_update ? w_avg : w_held_cur;

    always_ff @(posedge i_clk) begin
        if (r_m_valid && w_out_adv) begin
            r_out_ch    <= r_m_ch;
            r_out_level <= w_held_new[AVG_W-1 -: LVL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (w_m_load) begin
                r_m_valid <= o_pop;
            end
            if (w_out_adv) begin
                r_out_valid <= r_m_valid;
            end
            // held value only moves when its result is handed on
            if (r_m_valid && w_out_adv && w_update) begin
                r_held[w_m_idx] <= w_avg;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_level       = r_out_level;

    // Pending level always matches the channel's held value
    a_level_tracks_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_level == r_held[CH_IW'(r_out_ch)][AVG_W-1 -: LVL_W])
        else $error("reported level differs from held value");

    // Quotient of a burst sum never exceeds the 10-bit range
    a_avg_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> r_m_prod[PROD_W-1:DIV_SHIFT+AVG_W] == '0)
        else $error("average overflows 10 bits");

    // A product waiting on a stalled output is neither lost nor replaced
    a_mul_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && !w_out_adv |=> r_m_valid && $stable(r_m_prod) && $stable(r_m_ch))
        else $error("multiply stage overwritten while blocked");

endmodule

### hw/rtl/adc_average_hysteresis.sv
// Channel     | Direction | Signals                              | Accepted when
// sample in   | in        | i_valid, o_stall, i_channel, i_sample | i_valid && !o_stall
// level out   | out       | o_valid, i_stall, o_out_channel, o_level | o_valid && !i_stall
// config      | in        | i_cfg_wr_en, i_cfg_wr_data           | i_cfg_wr_en
//
// One sample request per cycle sustained while o_stall is low. A burst-closing sample is
// written to the queue at its accepting edge, then passes the reciprocal multiply register
// and the output register before its level shows.
// Reset (synchronous, active low) clears all per-channel sums, counts and held values
// at once; no clearing pass. o_stall rises only when the four-entry burst queue
// is full, which happens when i_stall has held the output long enough.
// Top level; depends on aah_pkg, aah_front, aah_fifo, aah_back.
`timescale 1ns / 1ps

module adc_average_hysteresis import aah_pkg::*; #(
    parameter int CHANNELS            = CHANNELS_DEF,
    parameter int SAMPLES_PER_READING = SPR_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [SMP_W-1:0] i_sample,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CH_W-1:0]  o_out_channel,
    output logic [LVL_W-1:0] o_level,
    input  logic             i_cfg_wr_en,
    input  logic [AVG_W-1:0] i_cfg_wr_data
);

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;
    t_burst w_push_entry;
    t_burst w_pop_entry;

    aah_front #(
        .CHANNELS            (CHANNELS),
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_channel (i_channel),
        .i_sample  (i_sample),
        .o_push    (w_push),
        .o_entry   (w_push_entry),
        .i_full    (w_full)
    );

    aah_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_empty (w_empty)
    );

    aah_back #(
        .CHANNELS            (CHANNELS),
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .i_entry       (w_pop_entry),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_level       (o_level)
    );

endmodule

### verif/tb_adc_average_hysteresis.sv
// Self-checking testbench for adc_average_hysteresis: burst averaging with a deadband.
// A scoreboard class predicts each channel's level; tasks drive the sample and config ports.
// Depends on aah_pkg and the adc_average_hysteresis RTL.
`timescale 1ns / 1ps

module tb_adc_average_hysteresis;
    import aah_pkg::*;

    localparam int NUM_CH   = CHANNELS_DEF;
    localparam int BURST    = SPR_DEF;
    localparam int PIPE_LAT = 3;
    localparam int SMP_MAX  = (1 << SMP_W) - 1;
    localparam int AVG_MASK = (1 << AVG_W) - 1;

    typedef struct {
        logic [CH_W-1:0]  ch;
        logic [LVL_W-1:0] level;
    } t_level_rec;

    // Mirrors per-channel accumulators and held values, queues expected levels
    class level_scoreboard;
        bit [AVG_W-1:0] window;
        bit [SUM_W-1:0] acc     [NUM_CH];
        bit [CNT_W-1:0] cnt     [NUM_CH];
        bit [AVG_W-1:0] held    [NUM_CH];
        t_level_rec     level_q [$];
        int             errors;

        function new();
            window = WINDOW_RESET;
            foreach (acc[k]) begin
                acc[k]  = '0;
                cnt[k]  = '0;
                held[k] = '0;
            end
            errors = 0;
        endfunction

        function void note_sample(bit [CH_W-1:0] ch, bit [SMP_W-1:0] smp);
            int         avg;
            int         diff;
            t_level_rec rec;
            if (ch >= NUM_CH) return;   // unused channel tags are dropped
            acc[ch] = acc[ch] + SUM_W'(smp);
            cnt[ch] = cnt[ch] + 1'b1;
            if (cnt[ch] < BURST) return;
            avg = (int'(acc[ch]) / BURST) & AVG_MASK;
            acc[ch] = '0;
            cnt[ch] = '0;
            // distance is taken as an absolute value, never wraps below zero
            diff = (avg > int'(held[ch])) ? avg - int'(held[ch]) : int'(held[ch]) - avg;
            if (diff > int'(window)) held[ch] = AVG_W'(avg);
            rec.ch    = ch;
            rec.level = LVL_W'(held[ch] >> 2);
            level_q.push_back(rec);
        endfunction

        function void check_level(logic [CH_W-1:0] ch, logic [LVL_W-1:0] level);
            t_level_rec rec;
            if (level_q.size() == 0) begin
                $error("unexpected level request: out_channel %0d level %0d", ch, level);
                errors++;
                return;
            end
            rec = level_q.pop_front();
            if (ch !== rec.ch) begin
                $error("out_channel mismatch: expected %0d, actual %0d", rec.ch, ch);
                errors++;
            end
            if (level !== rec.level) begin
                $error("level mismatch: expected %0d, actual %0d", rec.level, level);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [CH_W-1:0]  i_channel;
    logic [SMP_W-1:0] i_sample;
    logic             o_valid;
    logic             i_stall;
    logic [CH_W-1:0]  o_out_channel;
    logic [LVL_W-1:0] o_level;
    logic             i_cfg_wr_en;
    logic [AVG_W-1:0] i_cfg_wr_data;

    level_scoreboard sb = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int target [NUM_CH];

    adc_average_hysteresis DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_level       (o_level),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    // Receiver: long hold-off when requested, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_level(o_out_channel, o_level);
    end

    task automatic send_sample(input bit [CH_W-1:0] ch, input bit [SMP_W-1:0] smp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid   = 1'b0;
            i_channel = CH_W'($urandom);
            i_sample  = SMP_W'($urandom);
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_channel = ch;
        i_sample  = smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_sample(ch, smp);
    endtask

    task automatic drain_levels();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.level_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 3) @(posedge i_clk);
    endtask

    task automatic write_window(input bit [AVG_W-1:0] w);
        drain_levels();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = w;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sb.window     = w;
    endtask

    function automatic int clamp_sample(int v);
        if (v < 0) return 0;
        if (v > SMP_MAX) return SMP_MAX;
        return v;
    endfunction

    // Aim bursts at the edges of the deadband around the held value, at the sample extremes or at random
    function automatic int pick_target(int ch);
        int r;
        int offs;
        r    = $urandom_range(9);
        offs = int'(sb.window) + $urandom_range(3) - 1;
        case (r)
            0: return 0;
            1: return SMP_MAX;
            2, 3, 4: return clamp_sample(int'(sb.held[ch]) + offs);
            5, 6: return clamp_sample(int'(sb.held[ch]) - offs);
            default: return $urandom_range(SMP_MAX);
        endcase
    endfunction

    task automatic random_samples(input int n);
        int count;
        int ch;
        int r;
        int smp;
        count = 0;
        while (count < n) begin
            if ($urandom_range(19) == 0) begin
                send_sample(CH_W'(NUM_CH + $urandom_range((1 << CH_W) - 1 - NUM_CH)),
                            SMP_W'($urandom));
            end else begin
                ch = $urandom_range(NUM_CH - 1);
                if (sb.cnt[ch] == 0) target[ch] = pick_target(ch);
                r = $urandom_range(99);
                if (r < 10)      smp = $urandom_range(SMP_MAX);
                else if (r < 55) smp = target[ch];
                else             smp = clamp_sample(target[ch] + $urandom_range(4) - 2);
                send_sample(CH_W'(ch), SMP_W'(smp));
                count++;
            end
        end
    endtask

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_channel     = '0;
        i_sample      = '0;
        i_stall       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        foreach (target[k]) target[k] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: out-of-range channel at both sample extremes, then a full-scale burst
        send_sample(CH_W'(NUM_CH), SMP_W'(SMP_MAX));
        send_sample(CH_W'((1 << CH_W) - 1), '0);
        repeat (BURST) send_sample(CH_W'(NUM_CH - 1), SMP_W'(SMP_MAX));
        send_sample('0, '0);

        write_window('0);
        random_samples(250);

        send_idle_pct = 64;
        write_window(AVG_W'(AVG_MASK));
        random_samples(250);

        send_idle_pct = 0;
        stall_pct     = 64;
        write_window(AVG_W'($urandom_range(AVG_MASK)));
        random_samples(250);

        send_idle_pct = 15;
        stall_pct     = 15;
        write_window(AVG_W'(1));
        random_samples(250);

        // Backpressure: output held off long enough to fill the burst queue
        send_idle_pct = 0;
        stall_pct     = 0;
        write_window(AVG_W'(2));
        hold_left = 400;
        random_samples(250);
        drain_levels();
        random_samples(150);

        send_idle_pct = 15;
        stall_pct     = 15;
        write_window(AVG_W'($urandom_range(8)));
        random_samples(250);

        drain_levels();
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
